[rtl/rcpd_pkg.sv]
// rcpd_pkg: shared types and constants of the rc channel packet decoder
// request and result payloads, controller command and status groups
// no dependencies
package rcpd_pkg;

    localparam int CFG_W      = 24;
    localparam int CFG_IDX_W  = 2;
    localparam int WIDTH_W    = 16;
    localparam int TICK_W     = 24;
    localparam int ACTIVE_W   = 4;
    localparam int CHAN_IDX_W = 4;

    localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_CHANNELS   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT_TICKS     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_NEUTRAL_WIDTH     = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_THROTTLE_FS_WIDTH = 2'd3;

    localparam logic [ACTIVE_W-1:0] ACTIVE_RESET   = 4'd8;
    localparam logic [TICK_W-1:0]   TIMEOUT_RESET  = 24'd200000;
    localparam logic [WIDTH_W-1:0]  NEUTRAL_RESET  = 16'd1500;
    localparam logic [WIDTH_W-1:0]  THROTTLE_RESET = 16'd1000;
    localparam logic [TICK_W-1:0]   TICK_MAX       = 24'hFFFFFF;

    localparam int THROTTLE_CHANNEL = 2;

    localparam logic REQ_BYTE = 1'b0;
    localparam logic REQ_TICK = 1'b1;

    typedef struct packed {
        logic       req_type;
        logic [7:0] data_byte;
        logic       packet_start;
    } in_item_t;

    typedef struct packed {
        logic [CHAN_IDX_W-1:0] channel_index;
        logic [WIDTH_W-1:0]    pulse_width;
        logic                  signal_lost;
        logic                  last_channel;
    } out_item_t;

    typedef struct packed {
        logic take_item;
        logic search_init;
        logic search_eval;
        logic latch_hi;
        logic write_word;
        logic fill;
        logic emit_load;
    } cmd_t;

    typedef struct packed {
        logic pkt_full;
        logic fs_hit;
        logic span_big;
        logic n_zero;
        logic pair_found;
        logic search_end;
        logic last_word;
        logic last_emit;
        logic out_free;
    } status_t;

endpackage

[rtl/rcpd_ram.sv]
// rcpd_ram: generic simple dual-port ram with registered read
// one write port, one read port, no dependencies
module rcpd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[rtl/rcpd_ctrl.sv]
// rcpd_ctrl: sequencer of the rc channel packet decoder
// drives datapath commands from its status, uses rcpd_pkg
module rcpd_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  rcpd_pkg::status_t st,
    output rcpd_pkg::cmd_t    cmd,
    output logic              busy
);
    import rcpd_pkg::*;

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_SADDR = 4'd1;
    localparam logic [3:0] ST_SDATA = 4'd2;
    localparam logic [3:0] ST_HADDR = 4'd3;
    localparam logic [3:0] ST_HDATA = 4'd4;
    localparam logic [3:0] ST_LADDR = 4'd5;
    localparam logic [3:0] ST_LDATA = 4'd6;
    localparam logic [3:0] ST_FILL  = 4'd7;
    localparam logic [3:0] ST_EMIT  = 4'd8;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    assign busy = (state_reg != ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.take_item = 1'b1;
                    if (st.pkt_full && !st.span_big)
                    begin
                        cmd.search_init = 1'b1;
                        state_next      = ST_SADDR;
                    end
                    else if (st.fs_hit)
                    begin
                        state_next = ST_EMIT;
                    end
                end
            end
            ST_SADDR:
            begin
                state_next = ST_SDATA;
            end
            ST_SDATA:
            begin
                cmd.search_eval = 1'b1;
                if (st.pair_found)
                begin
                    state_next = st.n_zero ? ST_FILL : ST_HADDR;
                end
                else if (st.search_end)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    state_next = ST_SADDR;
                end
            end
            ST_HADDR:
            begin
                state_next = ST_HDATA;
            end
            ST_HDATA:
            begin
                cmd.latch_hi = 1'b1;
                state_next   = ST_LADDR;
            end
            ST_LADDR:
            begin
                state_next = ST_LDATA;
            end
            ST_LDATA:
            begin
                cmd.write_word = 1'b1;
                state_next     = st.last_word ? ST_FILL : ST_HADDR;
            end
            ST_FILL:
            begin
                cmd.fill   = 1'b1;
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (st.out_free)
                begin
                    cmd.emit_load = 1'b1;
                    if (st.last_emit)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

[rtl/rcpd_datapath.sv]
// rcpd_datapath: packet store, channel values, tick counter and result register
// acts on controller commands, uses rcpd_pkg and rcpd_ram
module rcpd_datapath #(
    parameter int PACKET_BYTES  = 32,
    parameter int CHANNEL_COUNT = 16
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  rcpd_pkg::in_item_t             in_data,
    input  logic                           out_stall,
    output logic                           out_valid,
    output rcpd_pkg::out_item_t            out_data,
    input  logic                           cfg_write,
    input  logic [rcpd_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [rcpd_pkg::CFG_W-1:0]     cfg_data,
    input  rcpd_pkg::cmd_t                 cmd,
    output rcpd_pkg::status_t              st
);
    import rcpd_pkg::*;

    localparam int RAW  = $clog2(PACKET_BYTES);
    localparam int PW   = $clog2(PACKET_BYTES + 2);
    localparam int CIW  = $clog2(CHANNEL_COUNT);
    localparam int CW   = $clog2(CHANNEL_COUNT + 1);
    localparam int SW   = (PW > CW + 1) ? PW : CW + 1;

    logic [RAW-1:0]      byte_count_reg, byte_count_next;
    logic [PW-1:0]       ptr_reg, ptr_next;
    logic                prev_zero_reg, prev_zero_next;
    logic [7:0]          hi_reg, hi_next;
    logic [CW-1:0]       c_reg, c_next;
    logic [TICK_W-1:0]   ticks_reg, ticks_next;
    logic                loss_reg, loss_next;
    logic [WIDTH_W-1:0]  ch_reg [CHANNEL_COUNT];
    logic [WIDTH_W-1:0]  ch_next [CHANNEL_COUNT];
    logic [ACTIVE_W-1:0] active_reg, active_next;
    logic [TICK_W-1:0]   timeout_reg, timeout_next;
    logic [WIDTH_W-1:0]  neutral_reg, neutral_next;
    logic [WIDTH_W-1:0]  throttle_reg, throttle_next;
    logic                out_valid_reg, out_valid_next;
    out_item_t           out_data_reg, out_data_next;

    logic [RAW-1:0]      wr_idx;
    logic                is_byte;
    logic                ram_we;
    logic [7:0]          rd_data;
    logic [7:0]          byte_val;
    logic [CW-1:0]       n_val;
    logic [SW-1:0]       span;
    logic [PW-1:0]       limit;
    logic [TICK_W-1:0]   ticks_inc;
    logic [WIDTH_W-1:0]  word;
    logic [CIW-1:0]      c_idx;

    assign is_byte = (in_data.req_type == REQ_BYTE);
    assign wr_idx  = in_data.packet_start ? '0 : byte_count_reg;
    assign ram_we  = cmd.take_item && is_byte;
    assign c_idx   = c_reg[CIW-1:0];

    rcpd_ram #(
        .WIDTH (8),
        .DEPTH (PACKET_BYTES)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (wr_idx),
        .wdata (in_data.data_byte),
        .raddr (ptr_reg[RAW-1:0]),
        .rdata (rd_data)
    );

    // positions at or past the end read as zero
    assign byte_val = (ptr_reg < PW'(PACKET_BYTES)) ? rd_data : 8'd0;

    always_comb
    begin
        if ({1'b0, active_reg} > (ACTIVE_W + 1)'(CHANNEL_COUNT))
        begin
            n_val = CW'(CHANNEL_COUNT);
        end
        else
        begin
            n_val = CW'(active_reg);
        end
    end

    assign span      = SW'({n_val, 1'b0});
    assign limit     = PW'(SW'(PACKET_BYTES) - span);
    assign ticks_inc = (ticks_reg == TICK_MAX) ? ticks_reg : ticks_reg + 1'b1;
    assign word      = {hi_reg, byte_val};

    assign st.pkt_full   = is_byte && (wr_idx == RAW'(PACKET_BYTES - 1));
    assign st.fs_hit     = !is_byte && (ticks_inc > timeout_reg) && !loss_reg;
    assign st.span_big   = (span >= SW'(PACKET_BYTES));
    assign st.n_zero     = (n_val == '0);
    assign st.pair_found = prev_zero_reg && (byte_val == 8'd0);
    assign st.search_end = (ptr_reg == limit);
    assign st.last_word  = ((c_reg + 1'b1) == n_val);
    assign st.last_emit  = (c_reg == CW'(CHANNEL_COUNT - 1));
    assign st.out_free   = !out_valid_reg || !out_stall;

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_comb
    begin
        byte_count_next = byte_count_reg;
        ptr_next        = ptr_reg;
        prev_zero_next  = prev_zero_reg;
        hi_next         = hi_reg;
        c_next          = c_reg;
        ticks_next      = ticks_reg;
        loss_next       = loss_reg;
        ch_next         = ch_reg;
        active_next     = active_reg;
        timeout_next    = timeout_reg;
        neutral_next    = neutral_reg;
        throttle_next   = throttle_reg;
        out_data_next   = out_data_reg;
        out_valid_next  = out_valid_reg && out_stall;

        if (cfg_write)
        begin
            unique case (cfg_index)
                REG_ACTIVE_CHANNELS:   active_next   = cfg_data[ACTIVE_W-1:0];
                REG_TIMEOUT_TICKS:     timeout_next  = cfg_data[TICK_W-1:0];
                REG_NEUTRAL_WIDTH:     neutral_next  = cfg_data[WIDTH_W-1:0];
                REG_THROTTLE_FS_WIDTH: throttle_next = cfg_data[WIDTH_W-1:0];
            endcase
        end

        if (cmd.take_item)
        begin
            if (is_byte)
            begin
                byte_count_next = st.pkt_full ? '0 : wr_idx + 1'b1;
            end
            else
            begin
                ticks_next = ticks_inc;
                if (st.fs_hit)
                begin
                    for (int k = 0; k < CHANNEL_COUNT; k++)
                    begin
                        ch_next[k] = neutral_reg;
                    end
                    ch_next[THROTTLE_CHANNEL] = throttle_reg;
                    loss_next = 1'b1;
                    c_next    = '0;
                end
            end
        end

        if (cmd.search_init)
        begin
            ptr_next       = '0;
            prev_zero_next = 1'b0;
            c_next         = '0;
        end

        if (cmd.search_eval)
        begin
            ptr_next       = ptr_reg + 1'b1;
            prev_zero_next = (byte_val == 8'd0);
        end

        if (cmd.latch_hi)
        begin
            hi_next  = byte_val;
            ptr_next = ptr_reg + 1'b1;
        end

        if (cmd.write_word)
        begin
            if (word != '0)
            begin
                ch_next[c_idx] = word;
            end
            ptr_next = ptr_reg + 1'b1;
            c_next   = c_reg + 1'b1;
        end

        if (cmd.fill)
        begin
            for (int k = 0; k < CHANNEL_COUNT; k++)
            begin
                if (CW'(k) >= n_val)
                begin
                    ch_next[k] = neutral_reg;
                end
            end
            ticks_next = '0;
            loss_next  = 1'b0;
            c_next     = '0;
        end

        if (cmd.emit_load)
        begin
            out_valid_next              = 1'b1;
            out_data_next.channel_index = CHAN_IDX_W'(c_reg);
            out_data_next.pulse_width   = ch_reg[c_idx];
            out_data_next.signal_lost   = loss_reg;
            out_data_next.last_channel  = st.last_emit;
            c_next                      = c_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_count_reg <= '0;
            ptr_reg        <= '0;
            prev_zero_reg  <= 1'b0;
            c_reg          <= '0;
            ticks_reg      <= '0;
            loss_reg       <= 1'b0;
            active_reg     <= ACTIVE_RESET;
            timeout_reg    <= TIMEOUT_RESET;
            neutral_reg    <= NEUTRAL_RESET;
            throttle_reg   <= THROTTLE_RESET;
            out_valid_reg  <= 1'b0;
            for (int k = 0; k < CHANNEL_COUNT; k++)
            begin
                ch_reg[k] <= (k == THROTTLE_CHANNEL) ? THROTTLE_RESET : NEUTRAL_RESET;
            end
        end
        else
        begin
            byte_count_reg <= byte_count_next;
            ptr_reg        <= ptr_next;
            prev_zero_reg  <= prev_zero_next;
            c_reg          <= c_next;
            ticks_reg      <= ticks_next;
            loss_reg       <= loss_next;
            active_reg     <= active_next;
            timeout_reg    <= timeout_next;
            neutral_reg    <= neutral_next;
            throttle_reg   <= throttle_next;
            out_valid_reg  <= out_valid_next;
            ch_reg         <= ch_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hi_reg       <= hi_next;
        out_data_reg <= out_data_next;
    end

endmodule

[rtl/rc_channel_packet_decoder_failsafe.sv]
// rc_channel_packet_decoder_failsafe: top level of the rc channel packet decoder
// joins the sequencer and the datapath, uses rcpd_pkg, rcpd_ctrl, rcpd_datapath
//
// Collects radio packet bytes into a PACKET_BYTES-entry store and, once the store
// is full, scans for the first pair of zero bytes and takes the active channels
// as big-endian words after it; nonzero words update the held channel values,
// unused channels go to neutral_width, and all CHANNEL_COUNT values come out in
// channel order with last_channel on the final one. A packet with no marker is
// dropped. Tick requests count time since the last good packet; past
// timeout_ticks the failsafe values are loaded once, signal_lost is set and all
// channels come out. A byte that does not complete a packet, and a tick that does
// not trip the failsafe, do not hold the input. A completing byte that starts a
// scan holds it through the scan, an address and a data state per store position
// (the store is a ram with registered read, one byte per read), the same for each
// byte of the active channels, the fill of unused channels and the output of all
// results, each once the output is free; a failsafe tick holds it for the output
// only. Configuration writes take effect at once and are meant for idle periods.
module rc_channel_packet_decoder_failsafe #(
    parameter int PACKET_BYTES  = 32,
    parameter int CHANNEL_COUNT = 16
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  rcpd_pkg::in_item_t             in_data,
    output logic                           out_valid,
    input  logic                           out_stall,
    output rcpd_pkg::out_item_t            out_data,
    input  logic                           cfg_write,
    input  logic [rcpd_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [rcpd_pkg::CFG_W-1:0]     cfg_data
);
    import rcpd_pkg::*;

    cmd_t    cmd;
    status_t st;

    rcpd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .st       (st),
        .cmd      (cmd),
        .busy     (in_stall)
    );

    rcpd_datapath #(
        .PACKET_BYTES  (PACKET_BYTES),
        .CHANNEL_COUNT (CHANNEL_COUNT)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (in_data),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .out_data  (out_data),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .st        (st)
    );

endmodule
